// File: rtl/phfla_pkg.sv
// ----------------------------------------------------------------------------
// Per-hart page free list allocator: shared types and constants
// Command, status and state codes, register indexes, fixed field widths and register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package phfla_pkg;

  localparam int unsigned AddrW   = 40;
  localparam int unsigned RegW    = 28;
  localparam int unsigned HartW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FREED     = 2'd1,
    ST_NO_MEM    = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FIRST_PAGE = 1'b0,
    REG_LIMIT_PAGE = 1'b1
  } reg_idx_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_POP  = 1'b1
  } fsm_e;

  localparam logic [RegW-1:0] FirstPageRst = 28'd0;
  localparam logic [RegW-1:0] LimitPageRst = 28'd4096;

endpackage

// File: rtl/per_hart_page_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// Per-hart page free list allocator
// LIFO free page list per hart, linked through a next-link memory; free
// pushes a checked page, allocate pops with round-robin stealing.
//
//   channel  | signals                                  | dir
//   ---------+------------------------------------------+-----
//   in       | in_valid_i/in_ready_o, cmd, hart, addr   | in
//   out      | out_valid_o/out_ready_i, status, addr... | out
//   cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i         | in
//
// Free and out-of-memory: result registered directly from the accepted word.
// Allocate: the next-link memory read is registered, then the POP state loads the result.
// A word is taken only when the result register is empty or draining.
// Reset empties every list; the link memory needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_hart_page_free_list_allocator_unit
  import phfla_pkg::*;
#(
  parameter int unsigned HARTS = 8,
  parameter int unsigned PAGES = 4096,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [HartW-1:0]   hart_i,
  input  logic [AddrW-1:0]   phys_addr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [AddrW-1:0]   page_addr_o,
  output logic [HartW-1:0]   from_hart_o
);

  localparam int unsigned HartIdxW = (HARTS > 1) ? $clog2(HARTS) : 1;
  localparam int unsigned PageW    = $clog2(PAGES);
  localparam int unsigned ModW     = HartW + HartIdxW;
  localparam logic [AddrW-1:0] PagesA = AddrW'(PAGES);
  localparam logic [ModW-1:0] HartsF = ModW'(HARTS);

  fsm_e state_q, state_d;

  logic [RegW-1:0] first_page_q, limit_page_q;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [AddrW-1:0]   out_addr_q, out_addr_d;
  logic [HartW-1:0]   out_from_q, out_from_d;
  logic               out_load;

  logic [HartIdxW-1:0] pop_hart_q, pop_hart_d;
  logic [PageW-1:0]    pop_page_q, pop_page_d;

  logic                accept;
  logic [HartIdxW-1:0] hart_mod;
  logic [AddrW-1:0]    page_num;
  logic                addr_good;

  logic                head_we, head_wvalid;
  logic [HartIdxW-1:0] head_widx, head_ridx, head_sel;
  logic [PageW-1:0]    head_wpage, head_rpage;
  logic                head_rvalid, head_found;

  logic               mem_we, mem_re;
  logic [PageW-1:0]   mem_waddr, mem_raddr;
  logic [PageW:0]     mem_wdata, mem_rdata;

  always_comb begin
    logic [ModW-1:0] v;
    v = ModW'(hart_i);
    for (int k = 0; k < (1 << HartW); k++) begin
      if (v >= HartsF) begin
        v = v - HartsF;
      end
    end
    hart_mod = HartIdxW'(v);
  end

  assign accept    = in_valid_i && in_ready_o;
  assign page_num  = phys_addr_i >> PAGE_SHIFT;
  assign addr_good = (phys_addr_i[PAGE_SHIFT-1:0] == '0)
                  && (page_num >= AddrW'(first_page_q))
                  && (page_num <  AddrW'(limit_page_q))
                  && (page_num <  PagesA);
  assign head_ridx = (cmd_i == CMD_FREE) ? hart_mod : head_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_page_q <= FirstPageRst;
      limit_page_q <= LimitPageRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FIRST_PAGE: first_page_q <= cfg_wdata_i;
        REG_LIMIT_PAGE: limit_page_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept && (cmd_i == CMD_ALLOC) && head_found) begin
          state_d = FSM_POP;
        end
      end
      FSM_POP: state_d = FSM_IDLE;
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    head_we      = 1'b0;
    head_widx    = hart_mod;
    head_wpage   = page_num[PageW-1:0];
    head_wvalid  = 1'b1;
    mem_we       = 1'b0;
    mem_waddr    = page_num[PageW-1:0];
    mem_wdata    = {head_rvalid, head_rpage};
    mem_re       = 1'b0;
    mem_raddr    = head_rpage;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_from_d   = out_from_q;
    pop_hart_d   = pop_hart_q;
    pop_page_d   = pop_page_q;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (accept) begin
          if (cmd_i == CMD_FREE) begin
            out_load   = 1'b1;
            out_addr_d = '0;
            out_from_d = '0;
            if (addr_good) begin
              head_we      = 1'b1;
              mem_we       = 1'b1;
              out_status_d = ST_FREED;
            end else begin
              out_status_d = ST_BAD_ADDR;
            end
          end else if (head_found) begin
            mem_re     = 1'b1;
            pop_hart_d = head_sel;
            pop_page_d = head_rpage;
          end else begin
            out_load     = 1'b1;
            out_status_d = ST_NO_MEM;
            out_addr_d   = '0;
            out_from_d   = '0;
          end
        end
      end
      FSM_POP: begin
        head_we      = 1'b1;
        head_widx    = pop_hart_q;
        head_wpage   = mem_rdata[PageW-1:0];
        head_wvalid  = mem_rdata[PageW];
        out_load     = 1'b1;
        out_status_d = ST_ALLOCATED;
        out_addr_d   = AddrW'(pop_page_q) << PAGE_SHIFT;
        out_from_d   = HartW'(pop_hart_q);
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_from_q   <= out_from_d;
    pop_hart_q   <= pop_hart_d;
    pop_page_q   <= pop_page_d;
  end

  phfla_head_file #(
    .Harts    (HARTS),
    .HartIdxW (HartIdxW),
    .PageW    (PageW)
  ) u_head_file (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (head_we),
    .widx_i   (head_widx),
    .wpage_i  (head_wpage),
    .wvalid_i (head_wvalid),
    .ridx_i   (head_ridx),
    .rpage_o  (head_rpage),
    .rvalid_o (head_rvalid),
    .start_i  (hart_mod),
    .found_o  (head_found),
    .sel_o    (head_sel)
  );

  phfla_link_mem #(
    .Depth (PAGES),
    .Width (PageW + 1)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign page_addr_o = out_addr_q;
  assign from_hart_o = out_from_q;

endmodule

// File: rtl/phfla_link_mem.sv
// ----------------------------------------------------------------------------
// Next-link memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phfla_link_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 13
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/phfla_head_file.sv
// ----------------------------------------------------------------------------
// List head registers
// One head and valid bit per hart, one write port, one read port, and a
// round-robin search for the first non-empty list from a start hart.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phfla_head_file #(
  parameter int unsigned Harts = 8,
  parameter int unsigned HartIdxW = 3,
  parameter int unsigned PageW = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [HartIdxW-1:0] widx_i,
  input  logic [PageW-1:0]    wpage_i,
  input  logic                wvalid_i,
  input  logic [HartIdxW-1:0] ridx_i,
  output logic [PageW-1:0]    rpage_o,
  output logic                rvalid_o,
  input  logic [HartIdxW-1:0] start_i,
  output logic                found_o,
  output logic [HartIdxW-1:0] sel_o
);

  localparam logic [HartIdxW:0] HartsW = (HartIdxW+1)'(Harts);

  logic [PageW-1:0] head_q [Harts];
  logic [Harts-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[widx_i] <= wvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      head_q[widx_i] <= wpage_i;
    end
  end

  assign rpage_o  = head_q[ridx_i];
  assign rvalid_o = valid_q[ridx_i];

  always_comb begin
    logic [HartIdxW:0] sum;
    found_o = 1'b0;
    sel_o   = '0;
    for (int k = Harts - 1; k >= 0; k--) begin
      sum = {1'b0, start_i} + (HartIdxW+1)'(k);
      if (sum >= HartsW) begin
        sum = sum - HartsW;
      end
      if (valid_q[sum[HartIdxW-1:0]]) begin
        found_o = 1'b1;
        sel_o   = sum[HartIdxW-1:0];
      end
    end
  end

endmodule
